[rtl/core/pfci_pkg.sv]
// pfci_pkg: shared types and constants of the parallel flash command interface
// request and response structs, command phases, register indexes and reset values
// no dependencies
`default_nettype none
package pfci_pkg;

  localparam int ADDR_W = 27;
  localparam int ADDR_BITS_DEF = 17;
  localparam int PAGE_TICKS_DEF = 268;
  localparam int BUFFER_BYTES = 32;
  localparam int PAGE_BYTES = 256;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data_byte;
  } pfci_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] mode_now;
    logic       modified;
  } pfci_rsp_t;

  // item functions
  localparam logic [1:0] FN_READ = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;
  localparam logic [1:0] FN_LOAD = 2'd3;

  // read modes
  localparam logic [1:0] RM_NORMAL = 2'd0;
  localparam logic [1:0] RM_AUTOSEL = 2'd1;
  localparam logic [1:0] RM_WSTATUS = 2'd2;
  localparam logic [1:0] RM_ESTATUS = 2'd3;

  // command styles
  localparam logic [1:0] ST_UNLOCK = 2'd0;
  localparam logic [1:0] ST_PAGE = 2'd1;
  localparam logic [1:0] ST_BUFFER = 2'd2;

  // unlock widths
  localparam logic [1:0] UW_15 = 2'd0;
  localparam logic [1:0] UW_11 = 2'd1;
  localparam logic [1:0] UW_12 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STYLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MFR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEV = 3'd6;

  // register reset values
  localparam logic [4:0] SECTOR_RST = 5'd14;
  localparam logic [4:0] CHIP_RST = 5'd17;
  localparam logic [7:0] WINDOW_RST = 8'd89;
  localparam logic [7:0] MFR_RST = 8'd1;
  localparam logic [7:0] DEV_RST = 8'd32;

  // command bytes
  localparam logic [7:0] CMD_AA = 8'hAA;
  localparam logic [7:0] CMD_55 = 8'h55;
  localparam logic [7:0] CMD_ERASE = 8'h80;
  localparam logic [7:0] CMD_AUTOSEL = 8'h90;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_RESET = 8'hF0;
  localparam logic [7:0] CMD_SECTOR = 8'h30;
  localparam logic [7:0] CMD_CHIP = 8'h10;
  localparam logic [7:0] CMD_UNPROT = 8'h20;
  localparam logic [7:0] CMD_BUFLOAD = 8'h25;
  localparam logic [7:0] CMD_CONFIRM = 8'h29;
  localparam logic [7:0] TOGGLE_MASK = 8'h44;

  // unlock addresses
  localparam logic [ADDR_W-1:0] ADR_5555 = 27'h5555;
  localparam logic [ADDR_W-1:0] ADR_2AAA = 27'h2AAA;
  localparam logic [ADDR_W-1:0] ADR_555 = 27'h555;
  localparam logic [ADDR_W-1:0] ADR_2AA = 27'h2AA;
  localparam logic [ADDR_W-1:0] ADR_AAA = 27'hAAA;
  localparam logic [ADDR_W-1:0] MSK_15 = 27'h7FFF;
  localparam logic [ADDR_W-1:0] MSK_11 = 27'h7FF;
  localparam logic [ADDR_W-1:0] MSK_12 = 27'hFFF;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_UNL1 = 5'd1,
    PH_CMD = 5'd2,
    PH_ERA_UNL0 = 5'd3,
    PH_ERA_UNL1 = 5'd4,
    PH_ERA_CMD = 5'd5,
    PH_PROGRAM = 5'd6,
    PH_P_UNL1 = 5'd7,
    PH_P_CMD = 5'd8,
    PH_P_ERA_UNL0 = 5'd9,
    PH_P_ERA_UNL1 = 5'd10,
    PH_P_ERA_CMD = 5'd11,
    PH_PAGE_FIRST = 5'd12,
    PH_PAGE_NEXT = 5'd13,
    PH_ERA_WINDOW = 5'd14,
    PH_BUF_COUNT = 5'd15,
    PH_BUF_FIRST = 5'd16,
    PH_BUF_NEXT = 5'd17,
    PH_BUF_CONFIRM = 5'd18
  } pfci_phase_t;

endpackage
`default_nettype wire

[rtl/core/parallel_flash_command_interface_unit.sv]
// parallel_flash_command_interface_unit: byte-wide nor flash array with its command sequencer
// depends on pfci_pkg
//
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  pfci_req_t (func, address, data_byte)
// rsp       out        rsp_valid / rsp_stall  pfci_rsp_t (read_data, mode_now, modified)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a read, tick, preload or plain command write passes through accept, execute and output.
// erases sweep the flash memory one byte a cycle through its single write port; a page
// write clears its page first, a buffer load start presets the buffer, a commit walks it.
// after rst the flash memory is swept to 0xFF with req_stall high.
// one request is in work at a time; req_stall stays high until its response is registered.
`default_nettype none
module parallel_flash_command_interface_unit #(
  parameter int ADDR_BITS = pfci_pkg::ADDR_BITS_DEF,
  parameter int PAGE_WRITE_TICKS = pfci_pkg::PAGE_TICKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire pfci_pkg::pfci_req_t           req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output pfci_pkg::pfci_rsp_t                rsp,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import pfci_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int BW = $clog2(BUFFER_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_FILL, S_WRB, S_BFILL, S_CRD, S_CWR, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [1:0] style, unlock_w;
  logic [4:0] sector_sh, chip_sh;
  logic [7:0] window_ticks, mfr_id, dev_id;

  // command state
  pfci_phase_t phase;
  logic [1:0]    read_mode;
  logic [7:0]    toggle;
  logic [8:0]    timer_count;
  logic          timer_armed, prot_on, modified_flag;
  logic [AW-1:0] pend_addr;
  logic [5:0]    pend_count;

  // latched request
  logic [1:0]    func_q;
  logic [AW-1:0] a_q;
  logic [7:0]    v_q, rd_q;

  // sweep control
  logic [AW-1:0] fill_base, fill_last, fill_off;
  logic          post_wr;
  logic [BW-1:0] bidx;

  // memories
  logic [7:0]    flash_mem [DEPTH];
  logic [7:0]    buf_mem [BUFFER_BYTES];
  logic          fw_en, bw_en;
  logic [AW-1:0] fw_addr, fr_addr;
  logic [7:0]    fw_data, fr_data, bw_data, br_data;
  logic [BW-1:0] bw_addr, br_addr;

  // derived address checks
  logic [ADDR_W-1:0] a27;
  logic              first_ok, second_ok, sec_out, buf_out;
  logic [AW-1:0]     sec_mask, chip_mask, page_base;

  function automatic logic [AW-1:0] shift_mask(input logic [4:0] sh);
    logic [4:0]  shc;
    logic [AW:0] m;
    shc = (sh > 5'(AW)) ? 5'(AW) : sh;
    m = ({{AW{1'b0}}, 1'b1} << shc) - {{AW{1'b0}}, 1'b1};
    return m[AW-1:0];
  endfunction

  assign a27 = ADDR_W'(a_q);
  assign sec_mask = shift_mask(sector_sh);
  assign chip_mask = shift_mask(chip_sh);
  assign page_base = a_q & ~AW'(PAGE_BYTES - 1);
  assign sec_out = ((a_q ^ pend_addr) & ~sec_mask) != '0;
  assign buf_out = ((a_q ^ pend_addr) & ~AW'(BUFFER_BYTES - 1)) != '0;

  // unlock address decode
  always_comb begin
    case (unlock_w)
      UW_11: begin
        first_ok = (a27 & MSK_11) == ADR_555;
        second_ok = (a27 & MSK_11) == ADR_2AA;
      end
      UW_12: begin
        first_ok = (a27 & MSK_12) == ADR_AAA;
        second_ok = (a27 & MSK_12) == ADR_555;
      end
      default: begin
        first_ok = (a27 & MSK_15) == ADR_5555;
        second_ok = (a27 & MSK_15) == ADR_2AAA;
      end
    endcase
  end

  // read addresses: request address while idle, commit walk otherwise
  always_comb begin
    if (state == S_IDLE) begin
      fr_addr = req.address[AW-1:0];
      br_addr = req.address[BW-1:0];
    end else begin
      fr_addr = {pend_addr[AW-1:BW], bidx};
      br_addr = bidx;
    end
  end

  // flash memory and program buffer
  always_ff @(posedge clk) begin
    if (fw_en) flash_mem[fw_addr] <= fw_data;
    fr_data <= flash_mem[fr_addr];
    if (bw_en) buf_mem[bw_addr] <= bw_data;
    br_data <= buf_mem[br_addr];
  end

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer, command state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      style <= ST_UNLOCK;
      unlock_w <= UW_15;
      sector_sh <= SECTOR_RST;
      chip_sh <= CHIP_RST;
      window_ticks <= WINDOW_RST;
      mfr_id <= MFR_RST;
      dev_id <= DEV_RST;
      phase <= PH_IDLE;
      read_mode <= RM_NORMAL;
      toggle <= '0;
      timer_count <= '0;
      timer_armed <= 1'b0;
      prot_on <= 1'b0;
      modified_flag <= 1'b0;
      pend_addr <= '0;
      pend_count <= '0;
      fill_off <= '0;
      fw_en <= 1'b0;
      bw_en <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      fw_en <= 1'b0;
      bw_en <= 1'b0;
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_STYLE: begin
            style <= (cfg_data[1:0] == 2'd3) ? ST_UNLOCK : cfg_data[1:0];
            prot_on <= (cfg_data[1:0] == ST_PAGE);
          end
          REG_UNLOCK: unlock_w <= (cfg_data[1:0] == 2'd3) ? UW_15 : cfg_data[1:0];
          REG_SECTOR: sector_sh <= cfg_data[4:0];
          REG_CHIP: chip_sh <= cfg_data[4:0];
          REG_WINDOW: window_ticks <= cfg_data;
          REG_MFR: mfr_id <= cfg_data;
          REG_DEV: dev_id <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        // clearing pass over the whole array, idle once the last byte is written
        S_CLEAR: begin
          fw_en <= 1'b1;
          fw_addr <= fill_off;
          fw_data <= 8'hFF;
          fill_off <= fill_off + 1'b1;
          if (fw_en && fw_addr == {AW{1'b1}}) begin
            fw_en <= 1'b0;
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            func_q <= req.func;
            a_q <= req.address[AW-1:0];
            v_q <= req.data_byte;
            rd_q <= 8'hFF;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_OUT;
          case (func_q)
            FN_READ: begin
              case (read_mode)
                RM_NORMAL: rd_q <= fr_data;
                RM_AUTOSEL: rd_q <= (a_q[7:0] == 8'd0) ? mfr_id :
                                    (a_q[7:0] == 8'd1) ? dev_id : 8'd0;
                RM_WSTATUS: rd_q <= {~fr_data[7], 7'd0};
                default: begin
                  rd_q <= toggle;
                  toggle <= toggle ^ TOGGLE_MASK;
                end
              endcase
            end
            FN_TICK: begin
              if (timer_armed && timer_count <= 9'd1) begin
                timer_armed <= 1'b0;
                timer_count <= '0;
                read_mode <= RM_NORMAL;
                phase <= (style == ST_PAGE && !prot_on) ? PH_PAGE_FIRST : PH_IDLE;
              end else if (timer_armed) begin
                timer_count <= timer_count - 1'b1;
              end
            end
            FN_LOAD: begin
              fw_en <= 1'b1;
              fw_addr <= a_q;
              fw_data <= v_q;
            end
            default: begin
              case (phase)
                PH_IDLE: begin
                  if (v_q == CMD_RESET) begin
                    if (read_mode != RM_NORMAL) begin
                      read_mode <= RM_NORMAL;
                      timer_armed <= 1'b0;
                      timer_count <= '0;
                    end
                  end else if (style == ST_PAGE) begin
                    if (a27 == ADR_5555 && v_q == CMD_AA) phase <= PH_P_UNL1;
                  end else if (first_ok && v_q == CMD_AA) begin
                    phase <= PH_UNL1;
                  end
                end
                PH_UNL1: phase <= (v_q == CMD_55 && second_ok) ? PH_CMD : PH_IDLE;
                PH_CMD: begin
                  if (style == ST_BUFFER && v_q == CMD_BUFLOAD) begin
                    pend_addr <= a_q;
                    phase <= PH_BUF_COUNT;
                  end else begin
                    phase <= PH_IDLE;
                    if (first_ok) begin
                      case (v_q)
                        CMD_ERASE: phase <= PH_ERA_UNL0;
                        CMD_AUTOSEL: read_mode <= RM_AUTOSEL;
                        CMD_PROGRAM: phase <= PH_PROGRAM;
                        CMD_RESET: read_mode <= RM_NORMAL;
                        default: ;
                      endcase
                    end
                  end
                end
                PH_ERA_UNL0: phase <= (v_q == CMD_AA && first_ok) ? PH_ERA_UNL1 : PH_IDLE;
                PH_ERA_UNL1: phase <= (v_q == CMD_55 && second_ok) ? PH_ERA_CMD : PH_IDLE;
                PH_ERA_CMD, PH_ERA_WINDOW: begin
                  if (phase == PH_ERA_CMD && v_q == CMD_CHIP && first_ok) begin
                    fill_base <= '0;
                    fill_last <= chip_mask;
                    fill_off <= '0;
                    post_wr <= 1'b0;
                    modified_flag <= 1'b1;
                    state <= S_FILL;
                    phase <= PH_IDLE;
                    read_mode <= RM_NORMAL;
                  end else if (v_q == CMD_SECTOR) begin
                    fill_base <= a_q & ~sec_mask;
                    fill_last <= sec_mask;
                    fill_off <= '0;
                    post_wr <= 1'b0;
                    modified_flag <= 1'b1;
                    state <= S_FILL;
                    if (window_ticks != 8'd0) begin
                      timer_armed <= 1'b1;
                      timer_count <= {1'b0, window_ticks};
                      phase <= PH_ERA_WINDOW;
                      read_mode <= RM_ESTATUS;
                    end else begin
                      timer_armed <= 1'b0;
                      timer_count <= '0;
                      phase <= PH_IDLE;
                      read_mode <= RM_NORMAL;
                    end
                  end else if (phase == PH_ERA_CMD) begin
                    phase <= PH_IDLE;
                    read_mode <= RM_NORMAL;
                  end
                end
                PH_PROGRAM: begin
                  fw_en <= 1'b1;
                  fw_addr <= a_q;
                  fw_data <= fr_data & v_q;
                  modified_flag <= 1'b1;
                  phase <= PH_IDLE;
                  read_mode <= RM_NORMAL;
                end
                PH_P_UNL1: phase <= (a27 == ADR_2AAA && v_q == CMD_55) ? PH_P_CMD : PH_IDLE;
                PH_P_CMD: begin
                  phase <= PH_IDLE;
                  if (a27 == ADR_5555) begin
                    case (v_q)
                      CMD_ERASE: phase <= PH_P_ERA_UNL0;
                      CMD_AUTOSEL: read_mode <= RM_AUTOSEL;
                      CMD_PROGRAM: begin
                        phase <= PH_PAGE_FIRST;
                        prot_on <= 1'b1;
                      end
                      CMD_RESET: read_mode <= RM_NORMAL;
                      default: ;
                    endcase
                  end
                end
                PH_P_ERA_UNL0:
                  phase <= (a27 == ADR_5555 && v_q == CMD_AA) ? PH_P_ERA_UNL1 : PH_IDLE;
                PH_P_ERA_UNL1:
                  phase <= (a27 == ADR_2AAA && v_q == CMD_55) ? PH_P_ERA_CMD : PH_IDLE;
                PH_P_ERA_CMD: begin
                  if (a27 == ADR_5555 && v_q == CMD_UNPROT) begin
                    prot_on <= 1'b0;
                    phase <= PH_PAGE_FIRST;
                  end else begin
                    if (a27 == ADR_5555 && v_q == CMD_CHIP) begin
                      fill_base <= '0;
                      fill_last <= chip_mask;
                      fill_off <= '0;
                      post_wr <= 1'b0;
                      modified_flag <= 1'b1;
                      state <= S_FILL;
                    end
                    read_mode <= RM_NORMAL;
                    phase <= PH_IDLE;
                  end
                end
                PH_PAGE_FIRST, PH_PAGE_NEXT: begin
                  modified_flag <= 1'b1;
                  timer_armed <= 1'b1;
                  timer_count <= 9'(PAGE_WRITE_TICKS);
                  if (phase == PH_PAGE_FIRST) begin
                    // clear the page, then store the byte
                    pend_addr <= page_base;
                    fill_base <= page_base;
                    fill_last <= AW'(PAGE_BYTES - 1);
                    fill_off <= '0;
                    post_wr <= 1'b1;
                    state <= S_FILL;
                    read_mode <= RM_WSTATUS;
                    phase <= PH_PAGE_NEXT;
                  end else begin
                    fw_en <= 1'b1;
                    fw_addr <= a_q;
                    fw_data <= v_q;
                  end
                end
                PH_BUF_COUNT: begin
                  if (v_q > 8'd31 || sec_out) begin
                    phase <= PH_IDLE;
                  end else begin
                    pend_count <= v_q[5:0] + 6'd1;
                    bidx <= '0;
                    state <= S_BFILL;
                    phase <= PH_BUF_FIRST;
                  end
                end
                PH_BUF_FIRST, PH_BUF_NEXT: begin
                  if (phase == PH_BUF_FIRST ? sec_out : buf_out) begin
                    phase <= PH_IDLE;
                  end else begin
                    if (phase == PH_BUF_FIRST) pend_addr <= a_q;
                    bw_en <= 1'b1;
                    bw_addr <= a_q[BW-1:0];
                    bw_data <= br_data & v_q;
                    pend_count <= pend_count - 6'd1;
                    phase <= (pend_count != 6'd1) ? PH_BUF_NEXT : PH_BUF_CONFIRM;
                  end
                end
                PH_BUF_CONFIRM: begin
                  phase <= PH_IDLE;
                  if (v_q == CMD_CONFIRM) begin
                    modified_flag <= 1'b1;
                    bidx <= '0;
                    state <= S_CRD;
                  end
                end
                default: phase <= PH_IDLE;
              endcase
            end
          endcase
        end

        // erase sweep, one byte a cycle
        S_FILL: begin
          fw_en <= 1'b1;
          fw_addr <= fill_base | fill_off;
          fw_data <= 8'hFF;
          fill_off <= fill_off + 1'b1;
          if (fill_off == fill_last) state <= post_wr ? S_WRB : S_OUT;
        end

        S_WRB: begin
          fw_en <= 1'b1;
          fw_addr <= a_q;
          fw_data <= v_q;
          state <= S_OUT;
        end

        // program buffer preset to 0xFF
        S_BFILL: begin
          bw_en <= 1'b1;
          bw_addr <= bidx;
          bw_data <= 8'hFF;
          bidx <= bidx + 1'b1;
          if (bidx == {BW{1'b1}}) state <= S_OUT;
        end

        // buffer commit: read both, then write the and
        S_CRD: state <= S_CWR;
        S_CWR: begin
          fw_en <= 1'b1;
          fw_addr <= {pend_addr[AW-1:BW], bidx};
          fw_data <= fr_data & br_data;
          bidx <= bidx + 1'b1;
          state <= (bidx == {BW{1'b1}}) ? S_OUT : S_CRD;
        end

        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.read_data <= rd_q;
            rsp.mode_now <= read_mode;
            rsp.modified <= modified_flag;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[verif/tb_parallel_flash_command_interface_unit.sv]
// tb_parallel_flash_command_interface_unit: self-checking bench for the flash command unit
// predicts every response with a behavioral flash model held in a scoreboard class
// depends on pfci_pkg and parallel_flash_command_interface_unit
`timescale 1ns / 100ps
module tb_parallel_flash_command_interface_unit;
  import pfci_pkg::*;

  localparam int ABITS = ADDR_BITS_DEF;
  localparam int unsigned AMASK = (1 << ABITS) - 1;

  // flash behavior model and response scoreboard
  class flash_scoreboard;
    logic [1:0] style, uwidth;
    logic [4:0] sec_shift, chip_shift;
    logic [7:0] win_ticks, mfr_id, dev_id;
    logic [7:0] mem[];
    logic [7:0] pbuf[BUFFER_BYTES];
    pfci_phase_t phase;
    logic [1:0] rmode;
    logic [7:0] toggles;
    int unsigned tcnt, padr, pcnt;
    bit armed, prot, mod;
    pfci_rsp_t expected_rsp[$];
    int errors;

    function new();
      mem = new[1 << ABITS];
      foreach (mem[i]) mem[i] = 8'hFF;
      foreach (pbuf[i]) pbuf[i] = 8'h00;
      style = ST_UNLOCK;
      uwidth = UW_15;
      sec_shift = SECTOR_RST;
      chip_shift = CHIP_RST;
      win_ticks = WINDOW_RST;
      mfr_id = MFR_RST;
      dev_id = DEV_RST;
      phase = PH_IDLE;
      rmode = RM_NORMAL;
      toggles = 8'h00;
      tcnt = 0;
      padr = 0;
      pcnt = 0;
      armed = 0;
      prot = 0;
      mod = 0;
      errors = 0;
    endfunction

    function bit first_ok(int unsigned a);
      if (uwidth == UW_11) return (a & MSK_11) == ADR_555;
      if (uwidth == UW_12) return (a & MSK_12) == ADR_AAA;
      return (a & MSK_15) == ADR_5555;
    endfunction

    function bit second_ok(int unsigned a);
      if (uwidth == UW_11) return (a & MSK_11) == ADR_2AA;
      if (uwidth == UW_12) return (a & MSK_12) == ADR_555;
      return (a & MSK_15) == ADR_2AAA;
    endfunction

    function int unsigned region_bytes(logic [4:0] shift);
      if (shift > ABITS) return 1 << ABITS;
      return 1 << shift;
    endfunction

    function void erase_region(int unsigned a, logic [4:0] shift);
      int unsigned size, base;
      size = region_bytes(shift);
      base = a & AMASK & ~(size - 1);
      for (int unsigned i = 0; i < size; i++) mem[base + i] = 8'hFF;
      mod = 1;
    endfunction

    function void stop_timer();
      armed = 0;
      tcnt = 0;
    endfunction

    function void start_timer(int unsigned n);
      armed = 1;
      tcnt = n & 'h1FF;
    endfunction

    function void timer_done();
      stop_timer();
      rmode = RM_NORMAL;
      phase = (style == ST_PAGE && !prot) ? PH_PAGE_FIRST : PH_IDLE;
    endfunction

    // sector erase, opening or restarting the erase window, or closing it for a zero window length
    function void window_erase(int unsigned a);
      erase_region(a, sec_shift);
      if (win_ticks != 0) begin
        start_timer(win_ticks);
        phase = PH_ERA_WINDOW;
        rmode = RM_ESTATUS;
      end else begin
        stop_timer();
        phase = PH_IDLE;
        rmode = RM_NORMAL;
      end
    endfunction

    // command sequencer for one bus write
    function void bus_write(int unsigned a, logic [7:0] v);
      int unsigned region, base, amask;
      region = region_bytes(sec_shift) - 1;
      case (phase)
        PH_IDLE: begin
          if (v == CMD_RESET) begin
            if (rmode != RM_NORMAL) begin
              rmode = RM_NORMAL;
              stop_timer();
            end
          end else if (style == ST_PAGE) begin
            if (a == ADR_5555 && v == CMD_AA) phase = PH_P_UNL1;
          end else if (first_ok(a) && v == CMD_AA) begin
            phase = PH_UNL1;
          end
        end
        PH_UNL1: phase = (v == CMD_55 && second_ok(a)) ? PH_CMD : PH_IDLE;
        PH_CMD: begin
          if (style == ST_BUFFER && v == CMD_BUFLOAD) begin
            padr = a;
            phase = PH_BUF_COUNT;
          end else begin
            phase = PH_IDLE;
            if (first_ok(a)) begin
              if (v == CMD_ERASE) phase = PH_ERA_UNL0;
              else if (v == CMD_AUTOSEL) rmode = RM_AUTOSEL;
              else if (v == CMD_PROGRAM) phase = PH_PROGRAM;
              else if (v == CMD_RESET) rmode = RM_NORMAL;
            end
          end
        end
        PH_ERA_UNL0: phase = (v == CMD_AA && first_ok(a)) ? PH_ERA_UNL1 : PH_IDLE;
        PH_ERA_UNL1: phase = (v == CMD_55 && second_ok(a)) ? PH_ERA_CMD : PH_IDLE;
        PH_ERA_CMD: begin
          if (v == CMD_CHIP && first_ok(a)) begin
            erase_region(0, chip_shift);
            phase = PH_IDLE;
            rmode = RM_NORMAL;
          end else if (v == CMD_SECTOR) begin
            window_erase(a);
          end else begin
            phase = PH_IDLE;
            rmode = RM_NORMAL;
          end
        end
        PH_PROGRAM: begin
          mem[a] = mem[a] & v;
          mod = 1;
          phase = PH_IDLE;
          rmode = RM_NORMAL;
        end
        PH_P_UNL1: phase = (a == ADR_2AAA && v == CMD_55) ? PH_P_CMD : PH_IDLE;
        PH_P_CMD: begin
          phase = PH_IDLE;
          if (a == ADR_5555) begin
            if (v == CMD_ERASE) phase = PH_P_ERA_UNL0;
            else if (v == CMD_AUTOSEL) rmode = RM_AUTOSEL;
            else if (v == CMD_PROGRAM) begin
              phase = PH_PAGE_FIRST;
              prot = 1;
            end else if (v == CMD_RESET) rmode = RM_NORMAL;
          end
        end
        PH_P_ERA_UNL0: phase = (a == ADR_5555 && v == CMD_AA) ? PH_P_ERA_UNL1 : PH_IDLE;
        PH_P_ERA_UNL1: phase = (a == ADR_2AAA && v == CMD_55) ? PH_P_ERA_CMD : PH_IDLE;
        PH_P_ERA_CMD: begin
          if (a == ADR_5555 && v == CMD_UNPROT) begin
            prot = 0;
            phase = PH_PAGE_FIRST;
          end else begin
            if (a == ADR_5555 && v == CMD_CHIP) erase_region(0, chip_shift);
            rmode = RM_NORMAL;
            phase = PH_IDLE;
          end
        end
        PH_PAGE_FIRST, PH_PAGE_NEXT: begin
          // first write of a page clears the page that holds it
          if (phase == PH_PAGE_FIRST) begin
            base = a & ~(PAGE_BYTES - 1);
            padr = base;
            for (int unsigned i = 0; i < PAGE_BYTES; i++) mem[base + i] = 8'hFF;
            rmode = RM_WSTATUS;
            phase = PH_PAGE_NEXT;
          end
          mem[a] = v;
          mod = 1;
          start_timer(PAGE_TICKS_DEF);
        end
        PH_ERA_WINDOW: if (v == CMD_SECTOR) window_erase(a);
        PH_BUF_COUNT: begin
          if (v > 31 || ((a ^ padr) & ~region) != 0) begin
            phase = PH_IDLE;
          end else begin
            foreach (pbuf[i]) pbuf[i] = 8'hFF;
            pcnt = v + 1;
            phase = PH_BUF_FIRST;
          end
        end
        PH_BUF_FIRST, PH_BUF_NEXT: begin
          amask = (phase == PH_BUF_FIRST) ? ~region : ~(BUFFER_BYTES - 1);
          if (((a ^ padr) & amask) != 0) begin
            phase = PH_IDLE;
          end else begin
            if (phase == PH_BUF_FIRST) padr = a;
            pbuf[a & (BUFFER_BYTES - 1)] = pbuf[a & (BUFFER_BYTES - 1)] & v;
            pcnt = (pcnt - 1) & 'h3F;
            phase = (pcnt != 0) ? PH_BUF_NEXT : PH_BUF_CONFIRM;
          end
        end
        PH_BUF_CONFIRM: begin
          if (v == CMD_CONFIRM) begin
            base = padr & AMASK & ~(BUFFER_BYTES - 1);
            for (int unsigned i = 0; i < BUFFER_BYTES; i++)
              mem[(base + i) & AMASK] = mem[(base + i) & AMASK] & pbuf[i];
            mod = 1;
          end
          phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // predict the response of one accepted request
    function void note_request(pfci_req_t r);
      int unsigned a;
      logic [7:0] rdata;
      a = r.address & AMASK;
      rdata = 8'hFF;
      case (r.func)
        FN_READ: begin
          case (rmode)
            RM_NORMAL: rdata = mem[a];
            RM_AUTOSEL: rdata = ((a & 'hFF) == 0) ? mfr_id : ((a & 'hFF) == 1) ? dev_id : 8'h00;
            RM_WSTATUS: rdata = ~mem[a] & 8'h80;
            default: begin
              rdata = toggles;
              toggles = toggles ^ TOGGLE_MASK;
            end
          endcase
        end
        FN_WRITE: bus_write(a, r.data_byte);
        FN_TICK: begin
          if (armed) begin
            if (tcnt > 0) tcnt--;
            if (tcnt == 0) timer_done();
          end
        end
        default: mem[a] = r.data_byte;
      endcase
      expected_rsp.push_back('{read_data: rdata, mode_now: rmode, modified: mod});
    endfunction

    // compare one accepted response with the oldest prediction
    function void check_response(pfci_rsp_t r);
      pfci_rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, r);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (r.read_data !== e.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, r.read_data);
        errors++;
      end
      if (r.mode_now !== e.mode_now) begin
        $display("%0t: mode_now expected %h actual %h", $time, e.mode_now, r.mode_now);
        errors++;
      end
      if (r.modified !== e.modified) begin
        $display("%0t: modified expected %h actual %h", $time, e.modified, r.modified);
        errors++;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_STYLE: begin
          style = val[1:0];
          if (style == 2'd3) style = ST_UNLOCK;
          prot = (style == ST_PAGE);
        end
        REG_UNLOCK: begin
          uwidth = val[1:0];
          if (uwidth == 2'd3) uwidth = UW_15;
        end
        REG_SECTOR: sec_shift = val[4:0];
        REG_CHIP: chip_shift = val[4:0];
        REG_WINDOW: win_ticks = val;
        REG_MFR: mfr_id = val;
        REG_DEV: dev_id = val;
        default: ;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  pfci_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pfci_rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  flash_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int items_sent = 0;
  int erase_left = 0;
  int chip_left = 0;
  logic [1:0] cur_style = ST_UNLOCK;
  logic [1:0] cur_uw = UW_15;
  logic [4:0] cur_sec = SECTOR_RST;
  logic [7:0] cur_win = WINDOW_RST;

  parallel_flash_command_interface_unit DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // response side stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // request and response monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  task automatic send(input logic [1:0] f, input int unsigned a, input int unsigned d);
    if ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: f, address: a[ADDR_W-1:0], data_byte: d[7:0]};
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic wr(input int unsigned a, input int unsigned d);
    send(FN_WRITE, a, d);
  endtask

  task automatic rd_byte(input int unsigned a);
    send(FN_READ, a, $urandom);
  endtask

  task automatic ticks(input int n);
    repeat (n) send(FN_TICK, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] s, input logic [7:0] u, input logic [7:0] sec,
                           input logic [7:0] chip, input logic [7:0] win,
                           input logic [7:0] mfr, input logic [7:0] dev);
    drain();
    write_reg(REG_STYLE, s);
    write_reg(REG_UNLOCK, u);
    write_reg(REG_SECTOR, sec);
    write_reg(REG_CHIP, chip);
    write_reg(REG_WINDOW, win);
    write_reg(REG_MFR, mfr);
    write_reg(REG_DEV, dev);
    cur_style = (s[1:0] == 2'd3) ? ST_UNLOCK : s[1:0];
    cur_uw = (u[1:0] == 2'd3) ? UW_15 : u[1:0];
    cur_sec = sec[4:0];
    cur_win = win;
  endtask

  // unlock address for the current style and width, with random don't-care bits
  function automatic int unsigned unl_addr(input bit second);
    int unsigned r;
    r = $urandom;
    if (cur_style == ST_PAGE) return (second ? ADR_2AAA : ADR_5555) | (r << ABITS);
    case (cur_uw)
      UW_11: return (second ? ADR_2AA : ADR_555) | (r << 11);
      UW_12: return (second ? ADR_555 : ADR_AAA) | (r << 12);
      default: return (second ? ADR_2AAA : ADR_5555) | (r << 15);
    endcase
  endfunction

  // addresses that mostly land in a small hot area
  function automatic int unsigned hot_addr();
    int unsigned r;
    r = $urandom;
    if ($urandom_range(0, 3) != 0) r = r & ~32'h0001_F800;
    return r;
  endfunction

  function automatic int unsigned not_sector_cmd();
    int unsigned d;
    d = $urandom_range(0, 255);
    if (d == CMD_SECTOR) d = CMD_SECTOR + 1;
    return d;
  endfunction

  task automatic unlock();
    wr(unl_addr(0), CMD_AA);
    wr(unl_addr(1), CMD_55);
  endtask

  task automatic erase_prefix();
    unlock();
    wr(unl_addr(0), CMD_ERASE);
    unlock();
  endtask

  task automatic seq_sector_erase();
    erase_prefix();
    wr(hot_addr(), CMD_SECTOR);
    erase_left--;
    // activity inside the erase window
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: if (erase_left > 0) begin
          wr(hot_addr(), CMD_SECTOR);
          erase_left--;
        end
        1: rd_byte(hot_addr());
        default: wr($urandom, not_sector_cmd());
      endcase
    end
    if (cur_win != 0 && (cur_win <= 20 || cur_sec >= 15 || $urandom_range(0, 4) == 0))
      ticks(cur_win + 1);
  endtask

  task automatic seq_chip_erase();
    erase_prefix();
    wr(unl_addr(0), CMD_CHIP);
    chip_left--;
  endtask

  task automatic seq_autoselect();
    int unsigned p;
    p = hot_addr() & ~32'hFF;
    unlock();
    wr(unl_addr(0), CMD_AUTOSEL);
    rd_byte(p);
    rd_byte(p | 1);
    rd_byte(p | $urandom_range(2, 255));
    if ($urandom_range(0, 1) != 0) wr($urandom, CMD_RESET);
    else begin
      unlock();
      wr(unl_addr(0), CMD_RESET);
    end
  endtask

  task automatic seq_program();
    int unsigned a;
    a = hot_addr();
    unlock();
    wr(unl_addr(0), CMD_PROGRAM);
    wr(a, $urandom);
    rd_byte(a);
  endtask

  task automatic seq_page_write();
    int unsigned p;
    p = hot_addr() & ~32'hFF;
    if ($urandom_range(0, 1) != 0) begin
      unlock();
      wr(unl_addr(0), CMD_PROGRAM);
    end else begin
      erase_prefix();
      wr(unl_addr(0), CMD_UNPROT);
    end
    repeat ($urandom_range(1, 6)) begin
      wr(p | $urandom_range(0, 255), not_sector_cmd());
      if ($urandom_range(0, 1) != 0) rd_byte(p | $urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) < 7) ticks(PAGE_TICKS_DEF + 1);
  endtask

  task automatic seq_buffer_load();
    int unsigned rgn, s, f, blk, n;
    rgn = 1 << ((cur_sec > ABITS) ? ABITS : cur_sec);
    s = hot_addr();
    unlock();
    wr(s, CMD_BUFLOAD);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 255) : $urandom_range(0, 31);
    if ($urandom_range(0, 9) == 0) wr(s ^ rgn, n);
    else wr(s, n);
    f = (s & ~(rgn - 1)) | ($urandom & (rgn - 1));
    if ($urandom_range(0, 15) == 0) f = f ^ rgn;
    blk = f & ~(BUFFER_BYTES - 1);
    wr(f, $urandom);
    repeat (n % 32) begin
      if ($urandom_range(0, 29) == 0) wr($urandom, $urandom);
      else wr(blk | $urandom_range(0, BUFFER_BYTES - 1), $urandom);
    end
    wr($urandom, ($urandom_range(0, 9) != 0) ? CMD_CONFIRM : not_sector_cmd());
    rd_byte(blk | $urandom_range(0, BUFFER_BYTES - 1));
  endtask

  task automatic seq_noise();
    if ($urandom_range(0, 1) != 0) begin
      send($urandom, $urandom, not_sector_cmd());
    end else begin
      wr(unl_addr(0), CMD_AA);
      wr($urandom, not_sector_cmd());
    end
  endtask

  task automatic random_phase(input int n, input int erases);
    int k, stop_at;
    stop_at = items_sent + n;
    erase_left = erases;
    chip_left = 2;
    while (items_sent < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 14) rd_byte(hot_addr());
      else if (k < 22) send(FN_LOAD, hot_addr(), $urandom);
      else if (k < 28) ticks($urandom_range(1, 5));
      else if (k < 42) begin
        if (cur_style == ST_PAGE) seq_page_write();
        else seq_program();
      end else if (k < 50) seq_autoselect();
      else if (k < 58) begin
        if (erase_left > 0) seq_sector_erase();
      end else if (k < 61) begin
        if (chip_left > 0 && cur_win <= 20) seq_chip_erase();
      end else if (k < 76) begin
        if (cur_style == ST_BUFFER) seq_buffer_load();
        else if (cur_style == ST_PAGE) seq_page_write();
        else seq_program();
      end else seq_noise();
    end
  endtask

  initial begin
    #150_000_000;
    $display("** parallel_flash_command_interface_unit: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // wait out the clearing sweep after reset
    do @(posedge clk); while (req_stall !== 1'b0);

    send_idle = 20;
    recv_idle = 48;
    // sector shift written with junk upper bits
    configure(ST_UNLOCK, UW_15, 8'hEC, 8'd27, 8'd3, 8'h00, 8'hFF);

    // directed: address extremes, preload, idle tick
    rd_byte(0);
    rd_byte(32'h07FF_FFFF);
    send(FN_LOAD, 0, 8'h00);
    send(FN_LOAD, 32'h07FF_FFFF, 8'h00);
    rd_byte(32'h07FF_FFFF);
    send(FN_TICK, 0, 0);
    // autoselect ids and reset
    unlock();
    wr(ADR_5555, CMD_AUTOSEL);
    rd_byte(32'h100);
    rd_byte(32'h101);
    rd_byte(32'h102);
    wr(0, CMD_RESET);
    // byte program and a failed unlock
    unlock();
    wr(ADR_5555, CMD_PROGRAM);
    wr(32'h10, 8'h3C);
    rd_byte(32'h10);
    wr(ADR_5555, CMD_AA);
    wr(32'h1234, CMD_55);
    // chip erase at a clamped device size
    erase_prefix();
    wr(ADR_5555, CMD_CHIP);
    // sector erase window with toggling status
    erase_prefix();
    wr(32'h2000, CMD_SECTOR);
    rd_byte(0);
    rd_byte(0);
    wr(0, CMD_RESET);
    // window length cleared while the window is open
    drain();
    write_reg(REG_WINDOW, 8'd0);
    wr(32'h3000, CMD_SECTOR);
    rd_byte(32'h3000);

    configure(ST_UNLOCK, UW_11, 8'd12, 8'd12, 8'd5, 8'hA5, 8'h5A);
    hold_left = 300;
    random_phase(130, 12);
    configure(ST_BUFFER, UW_12, 8'd13, 8'd12, 8'd0, 8'h01, 8'h20);
    random_phase(130, 12);

    send_idle = 48;
    recv_idle = 20;
    configure(ST_PAGE, UW_15, 8'd12, 8'd13, 8'd2, 8'h3C, 8'hC3);
    random_phase(130, 12);
    configure(8'd3, 8'd3, 8'd17, 8'd12, 8'd255, 8'hFF, 8'h00);
    random_phase(130, 1);

    send_idle = 0;
    recv_idle = 0;
    configure(ST_BUFFER, UW_15, 8'd12, 8'd12, 8'd4, 8'h96, 8'h69);
    random_phase(130, 12);
    configure(ST_PAGE, UW_11, 8'd14, 8'd12, 8'd1, 8'h11, 8'hEE);
    random_phase(130, 4);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** parallel_flash_command_interface_unit: PASSED **");
    end else begin
      $display("** parallel_flash_command_interface_unit: FAILED **");
    end
    $finish;
  end

endmodule
